/* hw/rtl/gsa_pkg.sv */
// ----------------------------------------------------------------------------
// gsa_pkg: generational slot allocator shared types and codes
//
// Command and response beat layouts, operation codes, status codes and
// change codes used by the allocator core.
// ----------------------------------------------------------------------------
package gsa_pkg;

    // Field widths of the command and response beats
    localparam int MODE_W    = 3;
    localparam int IDX_W     = 5;
    localparam int GEN_W     = 16;
    localparam int PAY_W     = 64;
    localparam int STATUS_W  = 2;
    localparam int KIND_W    = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DESTROY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_GET     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DEAD = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    // Change codes
    localparam logic [KIND_W-1:0] KIND_NONE      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CREATED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UPDATED   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DESTROYED = 2'd3;

    // Command beat
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  slot_index;
        logic [GEN_W-1:0]  handle_generation;
        logic [PAY_W-1:0]  payload;
    } t_cmd;

    // Response beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   change_kind;
        logic [IDX_W-1:0]    out_index;
        logic [GEN_W-1:0]    out_generation;
        logic [PAY_W-1:0]    out_payload;
        logic                last;
    } t_rsp;

endpackage

/* hw/rtl/generational_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// generational_slot_allocator_core: handle table with generation tags
//
// SLOTS entries, each with an alive bit, a generation tag and a record.
// Create pops a LIFO free stack or takes the next unused slot; update,
// destroy and get check the handle; clear destroys every alive slot and
// sends one beat per destroyed slot, or a single beat if none is alive.
//
//   channel   direction  handshake            beat
//   command   in         start && !busy       i_cmd (t_cmd)
//   response  out        o_strobe, one cycle  o_rsp (t_rsp)
//
// Create, update, destroy, get: accept, then the S_ADDR and S_EXEC working
// states; the response is strobed once back in idle, where a new command
// may already be accepted. Undefined codes answer from S_ADDR, the first
// working state. Clear: S_ADDR checks the table, then S_CLR_RD and S_CLR_WR
// per alive slot and S_CLR_RD alone per dead slot below the highest alive
// one; generation table reads are registered, so each kill is a read state
// followed by a write state. Reset is synchronous; the tables need no clearing
// pass, busy is low right after reset. The receiver cannot stall.
// ----------------------------------------------------------------------------
module generational_slot_allocator_core #(
    parameter int SLOTS       = 32,
    parameter int GEN_BITS    = 16,
    parameter int RECORD_BITS = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  gsa_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_strobe,
    output gsa_pkg::t_rsp o_rsp
);

    localparam int IW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > gsa_pkg::IDX_W) ? CW : gsa_pkg::IDX_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ADDR   = 5'b00010,
        S_EXEC   = 5'b00100,
        S_CLR_RD = 5'b01000,
        S_CLR_WR = 5'b10000
    } t_state;

    // Control state
    t_state             r_state,    n_state;
    logic [SLOTS-1:0]   r_alive,    n_alive;
    logic [SLOTS-1:0]   r_gen_vld,  n_gen_vld;
    logic [CW-1:0]      r_in_use,   n_in_use;
    logic [CW-1:0]      r_free_cnt, n_free_cnt;
    logic               r_strobe,   n_strobe;

    // Working registers
    gsa_pkg::t_cmd      r_cmd,      n_cmd;
    gsa_pkg::t_rsp      r_rsp,      n_rsp;
    logic [IW-1:0]      r_slot,     n_slot;
    logic [IW-1:0]      r_scan,     n_scan;
    logic               r_from_fs,  n_from_fs;
    logic               r_full,     n_full;
    logic               r_idx_ok,   n_idx_ok;

    // Tables
    logic [RECORD_BITS-1:0] r_rec_mem [SLOTS];
    logic [GEN_BITS-1:0]    r_gen_mem [SLOTS];
    logic [IW-1:0]          r_fs_mem  [SLOTS];
    logic [RECORD_BITS-1:0] r_rec_rd;
    logic [GEN_BITS-1:0]    r_gen_rd;
    logic                   r_gen_rv;
    logic [IW-1:0]          r_fs_rd;

    // Table control
    logic                w_rec_we;
    logic                w_kill;
    logic [IW-1:0]       w_kill_slot;
    logic [IW-1:0]       w_gen_ra;
    logic [IW-1:0]       w_fs_ra;
    logic [GEN_BITS-1:0] w_tag;
    logic [GEN_BITS-1:0] w_gen_inc;
    logic [GEN_BITS-1:0] w_gen_bump;
    logic [GEN_BITS-1:0] w_hg;
    logic                w_idx_ok;
    logic                w_live;
    logic [SLOTS-1:0]    w_rest;
    logic [RECORD_BITS-1:0] w_pay;

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // Shared tag unit: read tag, handle check and wrap-safe bump
    assign w_tag      = r_gen_rv ? r_gen_rd : '0;
    assign w_hg       = GEN_BITS'(r_cmd.handle_generation);
    assign w_gen_inc  = w_tag + GEN_BITS'(1);
    assign w_gen_bump = (w_gen_inc == '0) ? GEN_BITS'(1) : w_gen_inc;
    assign w_idx_ok   = CMPW'(r_cmd.slot_index) < CMPW'(r_in_use);
    assign w_live     = r_idx_ok && r_alive[r_slot] && (w_tag == w_hg);
    assign w_rest     = r_alive & ~(SLOTS'(1) << r_scan);
    assign w_pay      = r_cmd.payload[RECORD_BITS-1:0];
    assign w_fs_ra    = IW'(r_free_cnt - CW'(1));

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_alive     = r_alive;
        n_gen_vld   = r_gen_vld;
        n_in_use    = r_in_use;
        n_free_cnt  = r_free_cnt;
        n_strobe    = 1'b0;
        n_cmd       = r_cmd;
        n_rsp       = r_rsp;
        n_slot      = r_slot;
        n_scan      = r_scan;
        n_from_fs   = r_from_fs;
        n_full      = r_full;
        n_idx_ok    = r_idx_ok;
        w_rec_we    = 1'b0;
        w_kill      = 1'b0;
        w_kill_slot = r_slot;
        w_gen_ra    = r_scan;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_state = S_ADDR;
                end
            end

            // Pick the slot and start the table reads, or answer at once
            S_ADDR: begin
                n_idx_ok  = w_idx_ok;
                n_full    = 1'b0;
                n_from_fs = 1'b0;
                n_slot    = IW'(r_cmd.slot_index);
                n_state   = S_EXEC;
                unique case (r_cmd.mode)
                    gsa_pkg::MODE_CREATE: begin
                        if (r_free_cnt != '0) begin
                            n_from_fs = 1'b1;
                            n_slot    = r_fs_rd;
                        end else if (r_in_use < CW'(SLOTS)) begin
                            n_slot = IW'(r_in_use);
                        end else begin
                            n_full = 1'b1;
                        end
                    end
                    gsa_pkg::MODE_UPDATE,
                    gsa_pkg::MODE_DESTROY,
                    gsa_pkg::MODE_GET: begin
                    end
                    gsa_pkg::MODE_CLEAR: begin
                        if (r_alive == '0) begin
                            n_rsp      = '0;
                            n_rsp.last = 1'b1;
                            n_strobe   = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            n_scan  = '0;
                            n_state = S_CLR_RD;
                        end
                    end
                    default: begin
                        n_rsp      = '0;
                        n_rsp.last = 1'b1;
                        n_strobe   = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
                w_gen_ra = n_slot;
            end

            // Read data is in: check, write back and send the beat
            S_EXEC: begin
                n_strobe             = 1'b1;
                n_state              = S_IDLE;
                n_rsp.last           = 1'b1;
                n_rsp.out_index      = r_cmd.slot_index;
                n_rsp.out_generation = r_cmd.handle_generation;
                n_rsp.out_payload    = '0;
                n_rsp.change_kind    = gsa_pkg::KIND_NONE;
                n_rsp.status         = gsa_pkg::STATUS_OK;
                if (r_cmd.mode == gsa_pkg::MODE_CREATE) begin
                    if (r_full) begin
                        n_rsp.status         = gsa_pkg::STATUS_FULL;
                        n_rsp.out_index      = '0;
                        n_rsp.out_generation = '0;
                    end else begin
                        w_rec_we             = 1'b1;
                        n_alive[r_slot]      = 1'b1;
                        n_rsp.change_kind    = gsa_pkg::KIND_CREATED;
                        n_rsp.out_index      = gsa_pkg::IDX_W'(r_slot);
                        n_rsp.out_generation = gsa_pkg::GEN_W'(w_tag);
                        n_rsp.out_payload    = gsa_pkg::PAY_W'(w_pay);
                        if (r_from_fs) begin
                            n_free_cnt = r_free_cnt - CW'(1);
                        end else begin
                            n_in_use = r_in_use + CW'(1);
                        end
                    end
                end else if (!w_live) begin
                    n_rsp.status = gsa_pkg::STATUS_DEAD;
                end else begin
                    unique case (r_cmd.mode)
                        gsa_pkg::MODE_UPDATE: begin
                            w_rec_we          = 1'b1;
                            n_rsp.change_kind = gsa_pkg::KIND_UPDATED;
                            n_rsp.out_payload = gsa_pkg::PAY_W'(w_pay);
                        end
                        gsa_pkg::MODE_DESTROY: begin
                            w_kill            = 1'b1;
                            n_rsp.change_kind = gsa_pkg::KIND_DESTROYED;
                        end
                        default: begin
                            n_rsp.out_payload = gsa_pkg::PAY_W'(r_rec_rd);
                        end
                    endcase
                end
            end

            // Clear: skip dead slots, read the tag of an alive one
            S_CLR_RD: begin
                if (r_alive[r_scan]) begin
                    n_state = S_CLR_WR;
                end else begin
                    n_scan = r_scan + IW'(1);
                end
            end

            // Clear: kill the slot and send its beat
            S_CLR_WR: begin
                w_kill               = 1'b1;
                w_kill_slot          = r_scan;
                n_strobe             = 1'b1;
                n_rsp.status         = gsa_pkg::STATUS_OK;
                n_rsp.change_kind    = gsa_pkg::KIND_DESTROYED;
                n_rsp.out_index      = gsa_pkg::IDX_W'(r_scan);
                n_rsp.out_generation = gsa_pkg::GEN_W'(w_tag);
                n_rsp.out_payload    = '0;
                n_rsp.last           = (w_rest == '0);
                if (w_rest == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_scan  = r_scan + IW'(1);
                    n_state = S_CLR_RD;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Kill: clear alive, mark tag written, push on the free stack
        if (w_kill) begin
            n_alive[w_kill_slot]   = 1'b0;
            n_gen_vld[w_kill_slot] = 1'b1;
            if (r_free_cnt < CW'(SLOTS)) begin
                n_free_cnt = r_free_cnt + CW'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_alive    <= '0;
            r_gen_vld  <= '0;
            r_in_use   <= '0;
            r_free_cnt <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_alive    <= n_alive;
            r_gen_vld  <= n_gen_vld;
            r_in_use   <= n_in_use;
            r_free_cnt <= n_free_cnt;
            r_strobe   <= n_strobe;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_rsp     <= n_rsp;
        r_slot    <= n_slot;
        r_scan    <= n_scan;
        r_from_fs <= n_from_fs;
        r_full    <= n_full;
        r_idx_ok  <= n_idx_ok;
        r_gen_rv  <= r_gen_vld[w_gen_ra];
    end

    // Record table
    always_ff @(posedge i_clk) begin
        if (w_rec_we) begin
            r_rec_mem[r_slot] <= w_pay;
        end
        r_rec_rd <= r_rec_mem[n_slot];
    end

    // Generation table
    always_ff @(posedge i_clk) begin
        if (w_kill) begin
            r_gen_mem[w_kill_slot] <= w_gen_bump;
        end
        r_gen_rd <= r_gen_mem[w_gen_ra];
    end

    // Free stack: push at the count, top always read out
    always_ff @(posedge i_clk) begin
        if (w_kill && (r_free_cnt < CW'(SLOTS))) begin
            r_fs_mem[IW'(r_free_cnt)] <= w_kill_slot;
        end
        r_fs_rd <= r_fs_mem[w_fs_ra];
    end

    // Checks
    a_nonfinal_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_rsp.last) |-> busy)
        else $error("non-final beat while the sequencer is idle");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("beat strobed right after a command was taken");

    a_free_le_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= r_in_use)
        else $error("free stack deeper than the used slots");

    a_alive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alive >> r_in_use) == '0)
        else $error("alive slot beyond the used range");

endmodule

/* dv/generational_slot_allocator_core_tb.sv */
// ----------------------------------------------------------------------------
// generational_slot_allocator_core_tb: self-checking bench for the slot table
//
// Drives create, update, destroy, get, clear and undefined command beats
// with random idle gaps. A scoreboard class keeps its own copy of the handle
// table (alive bits, generation tags, records, LIFO free stack) and predicts
// every response beat. Each strobed response is checked field by field, in
// order, against the oldest prediction. The stimulus is a short directed
// pass, then random traffic built mostly from live handles.
// ----------------------------------------------------------------------------
module generational_slot_allocator_core_tb;
    import gsa_pkg::*;

    localparam int SLOTS        = 32;
    localparam int HALF_PERIOD  = 10;
    localparam int RAND_CMDS    = 245;
    localparam int DRAIN_CYCLES = 80;    // longer than a full-table clear
    localparam int MAX_SHOWN    = 10;

    // Scoreboard: mirror of the handle table plus queue of predicted beats
    class slot_table_ledger;
        t_rsp             expected_q[$];
        bit               alive      [SLOTS];
        logic [GEN_W-1:0] gen_tag    [SLOTS];
        logic [PAY_W-1:0] record     [SLOTS];
        logic [IDX_W-1:0] free_stack [SLOTS];
        int unsigned      used;
        int unsigned      free_cnt;
        int unsigned      errors;

        function new();
            for (int s = 0; s < SLOTS; s++) begin
                alive[s]      = 1'b0;
                gen_tag[s]    = '0;
                record[s]     = '0;
                free_stack[s] = '0;
            end
            used     = 0;
            free_cnt = 0;
            errors   = 0;
        endfunction

        function void push_rsp(logic [STATUS_W-1:0] status, logic [KIND_W-1:0] kind,
                               logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen,
                               logic [PAY_W-1:0] pay, logic last);
            t_rsp r;
            r.status         = status;
            r.change_kind    = kind;
            r.out_index      = idx;
            r.out_generation = gen;
            r.out_payload    = pay;
            r.last           = last;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function bit handle_live(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] gen);
            return (idx < used) && alive[idx] && (gen_tag[idx] == gen);
        endfunction

        // Kill: bump tag (zero skipped on wrap), drop record, push free stack
        function void retire_slot(int unsigned s);
            logic [GEN_W-1:0] nxt;
            nxt = gen_tag[s] + GEN_W'(1);
            if (nxt == '0) nxt = GEN_W'(1);
            gen_tag[s] = nxt;
            alive[s]   = 1'b0;
            record[s]  = '0;
            if (free_cnt < SLOTS) begin
                free_stack[free_cnt] = IDX_W'(s);
                free_cnt++;
            end
        endfunction

        // Accepted command beat: update the mirror, queue its responses
        function void note_command(t_cmd c);
            int unsigned      s;
            int unsigned      n;
            logic [GEN_W-1:0] g;
            case (c.mode)
                MODE_CREATE: begin
                    if (free_cnt > 0) begin
                        free_cnt--;
                        s = free_stack[free_cnt];
                    end else if (used < SLOTS) begin
                        s = used;
                        used++;
                    end else begin
                        push_rsp(STATUS_FULL, KIND_NONE, '0, '0, '0, 1'b1);
                        return;
                    end
                    record[s] = c.payload;
                    alive[s]  = 1'b1;
                    push_rsp(STATUS_OK, KIND_CREATED, IDX_W'(s), gen_tag[s], c.payload, 1'b1);
                end
                MODE_UPDATE, MODE_DESTROY, MODE_GET: begin
                    if (!handle_live(c.slot_index, c.handle_generation)) begin
                        push_rsp(STATUS_DEAD, KIND_NONE, c.slot_index, c.handle_generation,
                                 '0, 1'b1);
                    end else if (c.mode == MODE_UPDATE) begin
                        record[c.slot_index] = c.payload;
                        push_rsp(STATUS_OK, KIND_UPDATED, c.slot_index, c.handle_generation,
                                 c.payload, 1'b1);
                    end else if (c.mode == MODE_DESTROY) begin
                        retire_slot(c.slot_index);
                        push_rsp(STATUS_OK, KIND_DESTROYED, c.slot_index, c.handle_generation,
                                 '0, 1'b1);
                    end else begin
                        push_rsp(STATUS_OK, KIND_NONE, c.slot_index, c.handle_generation,
                                 record[c.slot_index], 1'b1);
                    end
                end
                MODE_CLEAR: begin
                    n = 0;
                    for (s = 0; s < used; s++) begin
                        if (alive[s]) begin
                            g = gen_tag[s];
                            retire_slot(s);
                            push_rsp(STATUS_OK, KIND_DESTROYED, IDX_W'(s), g, '0, 1'b0);
                            n++;
                        end
                    end
                    if (n == 0)
                        push_rsp(STATUS_OK, KIND_NONE, '0, '0, '0, 1'b1);
                    else
                        expected_q[expected_q.size()-1].last = 1'b1;
                end
                // undefined codes are ignored but still answered
                default: push_rsp(STATUS_OK, KIND_NONE, '0, '0, '0, 1'b1);
            endcase
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_SHOWN) $display("ERROR @%0t: %s", $time, msg);
        endfunction

        // Strobed response beat: compare with the oldest prediction
        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                flag($sformatf("response with none pending: st=%0d kind=%0d idx=%0d gen=%h",
                               got.status, got.change_kind, got.out_index, got.out_generation));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.change_kind !== want.change_kind ||
                got.out_index !== want.out_index || got.out_generation !== want.out_generation ||
                got.out_payload !== want.out_payload || got.last !== want.last)
                flag($sformatf({"exp st=%0d kind=%0d idx=%0d gen=%h pay=%h last=%0d, ",
                                "got st=%0d kind=%0d idx=%0d gen=%h pay=%h last=%0d"},
                               want.status, want.change_kind, want.out_index,
                               want.out_generation, want.out_payload, want.last,
                               got.status, got.change_kind, got.out_index,
                               got.out_generation, got.out_payload, got.last));
        endfunction

        // Random live handle, if any slot is alive
        function bit pick_live(output logic [IDX_W-1:0] idx, output logic [GEN_W-1:0] gen);
            int unsigned live_q[$];
            int unsigned k;
            for (int s = 0; s < SLOTS; s++)
                if (alive[s]) live_q.insert(live_q.size(), int'(s));
            idx = '0;
            gen = '0;
            if (live_q.size() == 0) return 1'b0;
            k   = live_q[$urandom_range(0, live_q.size() - 1)];
            idx = IDX_W'(k);
            gen = gen_tag[k];
            return 1'b1;
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_cmd i_cmd   = '0;
    logic busy;
    logic o_strobe;
    t_rsp o_rsp;

    slot_table_ledger ledger = new();
    int unsigned      calm_left = 0;

    generational_slot_allocator_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) ledger.check_response(o_rsp);
    end

    // Mostly short gaps, a few long ones, and now and then a run with none
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Drive one command beat and hold it until the core takes it
    task automatic issue_cmd(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                             input logic [GEN_W-1:0] gen, input logic [PAY_W-1:0] pay,
                             input int unsigned gap);
        t_cmd c;
        c.mode              = mode;
        c.slot_index        = idx;
        c.handle_generation = gen;
        c.payload           = pay;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        ledger.note_command(c);
    endtask

    // Handle for update/destroy/get: mostly live, some stale tag, some noise
    task automatic pick_handle(output logic [IDX_W-1:0] idx, output logic [GEN_W-1:0] gen);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85 && ledger.pick_live(idx, gen)) begin
            if (r >= 70) gen = gen ^ GEN_W'($urandom_range(1, 65535));
        end else begin
            idx = IDX_W'($urandom);
            gen = $urandom_range(0, 1) ? GEN_W'($urandom) : GEN_W'($urandom_range(0, 3));
        end
    endtask

    initial begin
        t_rsp              made;
        logic [IDX_W-1:0]  idx;
        logic [GEN_W-1:0]  gen;
        logic [MODE_W-1:0] mode;
        int unsigned       r;
        int unsigned       c_lim;
        int unsigned       u_lim;
        int unsigned       d_lim;
        int unsigned       g_lim;
        int unsigned       k_lim;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, extremes, LIFO reuse, undefined codes, clear
        issue_cmd(MODE_GET,     5'd0,  16'h0000, '0, idle_gap());  // never-used slot
        issue_cmd(MODE_CLEAR,   5'd0,  16'h0000, '0, idle_gap());  // nothing alive
        issue_cmd(MODE_CREATE,  5'd31, 16'hFFFF, '1, idle_gap());  // slot 0
        issue_cmd(MODE_CREATE,  5'd0,  16'h0000, '0, idle_gap());  // slot 1
        issue_cmd(MODE_CREATE,  5'd0,  16'h0000, 64'h0123_4567_89AB_CDEF, idle_gap());
        issue_cmd(MODE_UPDATE,  5'd1,  16'h0000, 64'hFEDC_BA98_7654_3210, idle_gap());
        issue_cmd(MODE_GET,     5'd1,  16'h0000, '0, idle_gap());
        issue_cmd(MODE_GET,     5'd0,  16'h0000, '0, idle_gap());
        issue_cmd(MODE_GET,     5'd1,  16'hFFFF, '0, idle_gap());  // wrong tag
        issue_cmd(MODE_UPDATE,  5'd31, 16'hFFFF, '1, idle_gap());  // index past used
        issue_cmd(MODE_DESTROY, 5'd0,  16'h0000, '1, idle_gap());
        issue_cmd(MODE_DESTROY, 5'd0,  16'h0000, '0, idle_gap());  // already dead
        issue_cmd(MODE_GET,     5'd0,  16'h0001, '0, idle_gap());  // dead, tag matches
        issue_cmd(MODE_CREATE,  5'd0,  16'h0000, 64'h5A5A_A5A5_0F0F_F0F0, idle_gap());
        issue_cmd(3'd5, IDX_W'($urandom), GEN_W'($urandom), {$urandom, $urandom},
                  idle_gap());
        issue_cmd(3'd6, 5'd0, 16'h0000, '0, idle_gap());
        issue_cmd(3'd7, 5'd31, 16'hFFFF, '1, idle_gap());
        issue_cmd(MODE_DESTROY, 5'd2,  16'h0000, '0, idle_gap());
        issue_cmd(MODE_DESTROY, 5'd1,  16'h0000, '0, idle_gap());
        issue_cmd(MODE_CREATE,  5'd0,  16'h0000, 64'h8000_0000_0000_0001, idle_gap());
        issue_cmd(MODE_CLEAR,   5'd31, 16'hFFFF, '1, idle_gap());  // two alive slots
        issue_cmd(MODE_GET,     5'd2,  16'h0001, '0, idle_gap());

        // Reuse a freed slot, then look it up with a stale and a live tag
        issue_cmd(MODE_CREATE, IDX_W'($urandom), GEN_W'($urandom), {$urandom, $urandom},
                  idle_gap());
        made = ledger.expected_q[$];
        issue_cmd(MODE_GET, made.out_index, '0, '0, idle_gap());
        issue_cmd(MODE_GET, made.out_index, made.out_generation, '0, idle_gap());

        // Random: create-heavy at first so the table fills, then a mix
        for (int n = 0; n < RAND_CMDS; n++) begin
            if (n < 100) begin
                c_lim = 60; u_lim = 72; d_lim = 80; g_lim = 92; k_lim = 92;
            end else begin
                c_lim = 30; u_lim = 50; d_lim = 70; g_lim = 89; k_lim = 96;
            end
            r = $urandom_range(0, 99);
            idx = IDX_W'($urandom);
            gen = GEN_W'($urandom);
            if (r < c_lim)      mode = MODE_CREATE;
            else if (r < u_lim) mode = MODE_UPDATE;
            else if (r < d_lim) mode = MODE_DESTROY;
            else if (r < g_lim) mode = MODE_GET;
            else if (r < k_lim) mode = MODE_CLEAR;
            else                mode = MODE_W'($urandom_range(5, 7));
            if (mode == MODE_UPDATE || mode == MODE_DESTROY || mode == MODE_GET)
                pick_handle(idx, gen);
            issue_cmd(mode, idx, gen, {$urandom, $urandom}, idle_gap());
        end
        start <= 1'b0;

        while (ledger.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.errors == 0 && ledger.expected_q.size() == 0)
            $display("generational_slot_allocator_core verification clean");
        else
            $display("generational_slot_allocator_core verification failed");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run (long gaps and full clears)
    initial begin
        #4_000_000;
        $display("generational_slot_allocator_core verification failed");
        $finish;
    end

endmodule
